// ----- sv/raf_pkg.sv -----
// Shared constants, types and state encoding of the running average filter.
package raf_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SAMPLE_BITS  = 32;
    localparam int WIN_BITS     = 6;
    localparam int POS_BITS     = $clog2(MAX_WINDOW);
    localparam int SUM_BITS     = SAMPLE_BITS + POS_BITS;
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int CNT_BITS     = $clog2(DIV_STEPS + 1);
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(20);
    localparam logic [WIN_BITS-1:0] WINDOW_MAX   = WIN_BITS'(MAX_WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } raf_state_t;

    typedef struct packed {
        logic clear;        // window write: drop all filter state
        logic load_sample;  // capture sample, read oldest entry
        logic update;       // replace oldest entry, update sum, position, count
        logic div_setup;    // load divider from sum and count
        logic div_step;     // one restoring division step
        logic load_out;     // register the signed quotient
    } raf_cmd_t;

    typedef struct packed {
        logic div_last;     // current step is the final one
    } raf_status_t;

endpackage

// ----- sv/raf_datapath.sv -----
// Datapath: sample ring, running sum, fill count, serial divider and result register.
module raf_datapath
    import raf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  raf_cmd_t                      cmd,
    output raf_status_t                   status,
    input  logic [WIN_BITS-1:0]           cfg_window_size,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic signed [SAMPLE_BITS-1:0] m_average
);

    localparam int EXT_BITS = SUM_BITS - SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  valid_reg, valid_next;

    logic [WIN_BITS-1:0]    window_reg, window_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [WIN_BITS-1:0]    fill_reg, fill_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] old_data_reg;
    logic                   old_valid_reg;

    logic [SUM_BITS-1:0]    quo_reg, quo_next;
    logic [WIN_BITS-1:0]    rem_reg, rem_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [SAMPLE_BITS-1:0] avg_reg;

    logic [SAMPLE_BITS-1:0] old_value;
    logic [WIN_BITS-1:0]    pos_inc;
    logic [WIN_BITS-1:0]    window_clamped;
    logic [WIN_BITS:0]      trial;
    logic                   trial_ge;
    logic [SUM_BITS-1:0]    quo_signed;

    always_comb begin
        window_clamped = cfg_window_size;
        if (cfg_window_size == '0) begin
            window_clamped = WIN_BITS'(1);
        end else if (cfg_window_size > WINDOW_MAX) begin
            window_clamped = WINDOW_MAX;
        end
    end

    assign old_value = old_valid_reg ? old_data_reg : '0;
    assign pos_inc   = {1'b0, pos_reg} + WIN_BITS'(1);

    always_comb begin
        window_next = window_reg;
        valid_next  = valid_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        if (cmd.clear) begin
            window_next = window_clamped;
            valid_next  = '0;
            pos_next    = '0;
            fill_next   = '0;
            sum_next    = '0;
        end else if (cmd.update) begin
            valid_next[pos_reg] = 1'b1;
            sum_next = sum_reg
                     - {{EXT_BITS{old_value[SAMPLE_BITS-1]}}, old_value}
                     + {{EXT_BITS{sample_reg[SAMPLE_BITS-1]}}, sample_reg};
            pos_next = (pos_inc >= window_reg) ? '0 : pos_inc[POS_BITS-1:0];
            if (fill_reg < window_reg) begin
                fill_next = fill_reg + WIN_BITS'(1);
            end
        end
    end

    // Restoring divider: magnitude of the sum by the fill count, one bit a cycle.
    assign trial    = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial_ge = trial >= {1'b0, fill_reg};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (cmd.div_setup) begin
            neg_next = sum_reg[SUM_BITS-1];
            quo_next = sum_reg[SUM_BITS-1] ? (~sum_reg + SUM_BITS'(1)) : sum_reg;
            rem_next = '0;
            cnt_next = CNT_BITS'(DIV_STEPS);
        end else if (cmd.div_step) begin
            if (trial_ge) begin
                rem_next = WIN_BITS'(trial - {1'b0, fill_reg});
            end else begin
                rem_next = trial[WIN_BITS-1:0];
            end
            quo_next = {quo_reg[SUM_BITS-2:0], trial_ge};
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    assign quo_signed      = neg_reg ? (~quo_reg + SUM_BITS'(1)) : quo_reg;
    assign status.div_last = (cnt_reg == CNT_BITS'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            valid_reg  <= '0;
            pos_reg    <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            window_reg <= window_next;
            valid_reg  <= valid_next;
            pos_reg    <= pos_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        if (cmd.load_sample) begin
            sample_reg    <= s_sample;
            old_data_reg  <= store_mem[pos_reg];
            old_valid_reg <= valid_reg[pos_reg];
        end
        if (cmd.update) begin
            store_mem[pos_reg] <= sample_reg;
        end
        if (cmd.load_out) begin
            avg_reg <= quo_signed[SAMPLE_BITS-1:0];
        end
    end

    assign m_average = avg_reg;

endmodule

// ----- sv/raf_controller.sv -----
// Controller: sequences one sample through update, division and result hand-off.
module raf_controller
    import raf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  raf_status_t status,
    output raf_cmd_t    cmd
);

    raf_state_t state_reg, state_next;
    logic       out_full_reg, out_full_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid) begin
                    cmd.clear = 1'b1;
                end else if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.div_setup = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the result register is free
                if (!out_full_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_full_next = out_full_reg;
        if (cmd.load_out) begin
            out_full_next = 1'b1;
        end else if (m_ready) begin
            out_full_next = 1'b0;
        end
    end

    assign m_valid = out_full_reg;

endmodule

// ----- sv/running_average_filter.sv -----
// Top level of the running average filter: controller and datapath.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_sample        (32 bits signed)
//  m_        out        m_valid / m_ready      m_average       (32 bits signed)
//  cfg_      in         cfg_valid / cfg_ready  cfg_window_size (6 bits unsigned)
//
// Each sample transaction runs from its accept to the earliest next accept through these steps:
// an accept that reads the oldest ring entry, an update of the ring and sum, a
// divider setup, 37 restoring division steps and a load of the result.
// The 37 steps come from the serial divider, one quotient bit per cycle.
// The result register parts the two sides: a finished result may wait on m_ready
// while the next sample is accepted; only a further result stalls behind it.
// Reset and any window write clear the ring (per-entry valid bits, at once), the
// position, the fill count and the sum; no clearing pass is needed.
module running_average_filter
    import raf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [WIN_BITS-1:0]           cfg_window_size
);

    raf_cmd_t    cmd;
    raf_status_t status;

    // Sequence each transaction and own the output valid flag.
    raf_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the ring, sum, count, divider and result register.
    raf_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_window_size (cfg_window_size),
        .s_sample        (s_sample),
        .m_average       (m_average)
    );

endmodule

// ----- sv/raf_checker.sv -----
// Port-level checker for the running average filter, with its bind.
module raf_checker
    import raf_pkg::*;
(
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_average,
    input logic                          cfg_ready
);

    // A waiting result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_average)))
        else $error("result changed while stalled");

    // One sample at a time: no second transaction straight after the first.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample accepted while one is in flight");

    // Configuration is closed while a sample is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !cfg_ready)
        else $error("configuration open during a transaction");

    // A result never appears in the cycle after a sample is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind running_average_filter raf_checker u_raf_checker (.*);
